// File: rtl/core/trimmed_mean_sample_filter_core_defines.svh
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_CORE_DEFINES_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checks skipped while reset is high.
`define TMSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checks skipped while reset is high.
`define TMSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tmsf_pkg.sv
package tmsf_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 14;
  localparam int COUNT_W  = 4;
  localparam int TDATA_W  = 16;

  localparam int RAW_GROUP   = 11;
  localparam int MED_GROUP   = 8;
  localparam int RAW_DIVISOR = RAW_GROUP - 2;
  localparam int MED_DIVISOR = MED_GROUP - 2;

  // Divide by multiply: q = (x * ceil(2^17 / d)) >> 17, exact for x below 2^15.
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_W     = 15;
  localparam int RAW_RECIP   = ((2 ** RECIP_SHIFT) + RAW_DIVISOR - 1) / RAW_DIVISOR;
  localparam int MED_RECIP   = ((2 ** RECIP_SHIFT) + MED_DIVISOR - 1) / MED_DIVISOR;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef enum logic {
    MODE_RAW    = 1'b0,
    MODE_MEDIAN = 1'b1
  } filter_mode_t;

  typedef struct packed {
    filter_mode_t        mode;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] max;
    logic [SAMPLE_W-1:0] min;
  } group_done_t;

  function automatic logic [SAMPLE_W-1:0] median3(
    input logic [SAMPLE_W-1:0] a,
    input logic [SAMPLE_W-1:0] b,
    input logic [SAMPLE_W-1:0] c
  );
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c > hi) begin
      return hi;
    end else if (c > lo) begin
      return c;
    end
    return lo;
  endfunction

endpackage

// File: rtl/core/tmsf_accum.sv
module tmsf_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic                              cfg_mode,
  input  logic                              step,
  input  logic [tmsf_pkg::SAMPLE_W-1:0]     sample,
  output logic                              done_valid,
  output tmsf_pkg::group_done_t             done
);
  import tmsf_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  filter_mode_t        mode;
  phase_t              phase;
  phase_t              phase_next;
  logic [SAMPLE_W-1:0] first_raw;
  logic [SAMPLE_W-1:0] second_raw;
  logic [COUNT_W-1:0]  count;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] max;
  logic [SAMPLE_W-1:0] min;

  logic [SAMPLE_W-1:0] elem;
  logic                use_elem;
  logic [COUNT_W-1:0]  count_next;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [COUNT_W-1:0]  group_size;
  logic                full;

  always_comb begin
    elem       = sample;
    use_elem   = 1'b0;
    phase_next = phase;
    if (mode == MODE_RAW) begin
      use_elem = 1'b1;
    end else begin
      case (phase)
        PH_SECOND: begin
          phase_next = PH_THIRD;
        end
        PH_THIRD: begin
          elem       = median3(first_raw, second_raw, sample);
          use_elem   = 1'b1;
          phase_next = PH_FIRST;
        end
        default: begin
          phase_next = PH_SECOND;
        end
      endcase
    end
  end

  assign sum_next   = sum + {{(SUM_W-SAMPLE_W){1'b0}}, elem};
  assign max_next   = (elem > max) ? elem : max;
  assign min_next   = (elem < min) ? elem : min;
  assign count_next = count + COUNT_W'(1);
  assign group_size = (mode == MODE_RAW) ? COUNT_W'(RAW_GROUP) : COUNT_W'(MED_GROUP);
  assign full       = (count_next >= group_size);

  assign done_valid = step && use_elem && full;
  assign done       = '{mode: mode, sum: sum_next, max: max_next, min: min_next};

  // Payload of the open triple.
  always_ff @(posedge clk) begin
    if (step && (mode == MODE_MEDIAN)) begin
      if (phase == PH_SECOND) begin
        second_raw <= sample;
      end else if (phase != PH_THIRD) begin
        first_raw <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      mode  <= rst ? MODE_RAW : filter_mode_t'(cfg_mode);
      phase <= PH_FIRST;
      count <= '0;
      sum   <= '0;
      max   <= '0;
      min   <= '1;
    end else if (step) begin
      phase <= phase_next;
      if (use_elem) begin
        if (full) begin
          count <= '0;
          sum   <= '0;
          max   <= '0;
          min   <= '1;
        end else begin
          count <= count_next;
          sum   <= sum_next;
          max   <= max_next;
          min   <= min_next;
        end
      end
    end
  end

endmodule

// File: rtl/core/trimmed_mean_sample_filter_core.sv
// Channel   | Direction | Signals                               | Contents
// ----------+-----------+---------------------------------------+--------------------------------
// s_axis    | in        | s_axis_tvalid/tready/tdata[15:0]      | sample [9:0]
// m_axis    | out       | m_axis_tvalid/tready/tdata[15:0]      | filtered_value [9:0]
// cfg       | in        | cfg_wen, cfg_wdata[0:0]               | filter_mode, write only
//
// One sample per cycle sustained while m_axis accepts. A sample passes an input
// register, the group update (median of three, add, max/min compare), a
// completed-group register and the divide-by-multiply output register.
// Reset (rst, synchronous) empties all stages, selects the raw mode and restarts
// the group. A cfg write restarts the group too.
// A stalled m_axis holds its transaction; the stages behind it keep filling, and
// s_axis drops tready only once the input and group registers are both held.
module trimmed_mean_sample_filter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [0:0]                    cfg_wdata,      // [0] filter_mode
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tmsf_pkg::TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tmsf_pkg::TDATA_W-1:0]  m_axis_tdata    // [9:0] filtered_value
);
  import tmsf_pkg::*;

  // Input register.
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_adv;

  // Completed-group register.
  logic                done_valid;
  group_done_t         done;
  logic                grp_valid;
  group_done_t         grp;
  logic                grp_ready;

  // Output register.
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_value;
  logic                out_free;

  logic [SUM_W-1:0]    trimmed;
  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod;

  assign out_free  = !out_valid || m_axis_tready;
  assign grp_ready = !grp_valid || out_free;
  assign in_adv    = in_valid && grp_ready;

  assign s_axis_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  // Group state: advance on every sample that leaves the input register.
  tmsf_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_mode   (cfg_wdata[0]),
    .step       (in_adv),
    .sample     (in_sample),
    .done_valid (done_valid),
    .done       (done)
  );

  // Hold the totals of a finished group until the output register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (grp_ready) begin
      grp_valid <= in_adv && done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_ready) begin
      grp <= done;
    end
  end

  // Drop the extremes, then divide by group size minus two via the reciprocal.
  assign trimmed = grp.sum - {{(SUM_W-SAMPLE_W){1'b0}}, grp.max}
                           - {{(SUM_W-SAMPLE_W){1'b0}}, grp.min};
  assign recip   = (grp.mode == MODE_RAW) ? RECIP_W'(RAW_RECIP) : RECIP_W'(MED_RECIP);
  assign prod    = PROD_W'(trimmed) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_value <= prod[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TDATA_W-SAMPLE_W){1'b0}}, out_value};

endmodule

// File: rtl/core/tmsf_checker.sv
`include "trimmed_mean_sample_filter_core_defines.svh"

module tmsf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tmsf_pkg::TDATA_W-1:0]  m_axis_tdata
);

  // A stalled result transaction holds its valid and its data.
  `TMSF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "m_axis transaction changed while stalled")

  // All stages are empty right after reset, so the input side is open.
  `TMSF_ASSERT_NOW(a_ready_after_rst, clk, rst, $past(rst), s_axis_tready, "s_axis_tready low after reset")

  // A fresh result on m_axis must go back to an accepted s_axis sample transaction.
  `TMSF_ASSERT_NOW(a_out_latency, clk, rst, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 3), "result without closing sample three cycles back")

endmodule

bind trimmed_mean_sample_filter_core tmsf_checker u_tmsf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
